FILE: sv/sdmcp_pkg.sv
// ----------------------------------------------------------------------------
// sdmcp_pkg
// Types and character codes shared by the dual motor command parser.
// ----------------------------------------------------------------------------
package sdmcp_pkg;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_COLON   = 4'd1,
        PH_L_BLANK = 4'd2,
        PH_L_SIGN  = 4'd3,
        PH_L_DIG   = 4'd4,
        PH_L_DONE  = 4'd5,
        PH_R_BLANK = 4'd6,
        PH_R_SIGN  = 4'd7,
        PH_R_DIG   = 4'd8,
        PH_R_DONE  = 4'd9,
        PH_REJECT  = 4'd10
    } t_phase;

    typedef struct packed {
        logic push;
        logic left_forward;
        logic left_reverse;
        logic right_forward;
        logic right_reverse;
    } t_res_ctl;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] PWM_LIMIT_RESET = 8'd255;

endpackage

FILE: sv/sdmcp_byte_if.sv
// ----------------------------------------------------------------------------
// sdmcp_byte_if
// Received character channel.
// ----------------------------------------------------------------------------
interface sdmcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: sv/sdmcp_drive_if.sv
// ----------------------------------------------------------------------------
// sdmcp_drive_if
// Motor drive result channel.
// ----------------------------------------------------------------------------
interface sdmcp_drive_if #(
    parameter int DUTY_BITS = 10
);
    logic                 valid;
    logic                 ready;
    logic                 left_forward;
    logic                 left_reverse;
    logic [DUTY_BITS-1:0] left_duty;
    logic                 right_forward;
    logic                 right_reverse;
    logic [DUTY_BITS-1:0] right_duty;

    modport source (
        output valid, output left_forward, output left_reverse, output left_duty,
        output right_forward, output right_reverse, output right_duty,
        input ready
    );
    modport sink (
        input valid, input left_forward, input left_reverse, input left_duty,
        input right_forward, input right_reverse, input right_duty,
        output ready
    );
endinterface

FILE: sv/sdmcp_parse.sv
// ----------------------------------------------------------------------------
// sdmcp_parse
// Per-character line parser: phase, field magnitudes and signs, and the
// drive values produced when a valid line ends.
// ----------------------------------------------------------------------------
module sdmcp_parse import sdmcp_pkg::*; #(
    parameter int DUTY_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_rx_byte,
    input  logic [DUTY_BITS-1:0] i_pwm_limit,
    output t_res_ctl             o_ctl,
    output logic [DUTY_BITS-1:0] o_left_duty,
    output logic [DUTY_BITS-1:0] o_right_duty
);

    localparam int MAG_W = DUTY_BITS + 1;
    localparam int ACC_W = MAG_W + 4;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    t_phase           r_phase, n_phase;
    logic [MAG_W-1:0] r_lmag, n_lmag, r_rmag, n_rmag;
    logic             r_lneg, n_lneg, r_rneg, n_rneg;

    logic             c_blank, c_digit, c_sign, c_minus;
    logic [MAG_W-1:0] left_acc, right_acc;

    function automatic logic [MAG_W-1:0] accumulate(input logic [MAG_W-1:0] mag,
                                                    input logic [3:0] dig);
        logic [ACC_W-1:0] v;
        v = ACC_W'(mag) * ACC_W'(10) + ACC_W'(dig);
        return (v > ACC_W'(MAG_MAX)) ? MAG_MAX : v[MAG_W-1:0];
    endfunction

    function automatic logic [DUTY_BITS-1:0] clamp(input logic [MAG_W-1:0] mag,
                                                   input logic [DUTY_BITS-1:0] lim);
        return (mag > MAG_W'(lim)) ? lim : mag[DUTY_BITS-1:0];
    endfunction

    assign c_blank = (i_rx_byte == CH_SPACE) || (i_rx_byte == CH_TAB) ||
                     (i_rx_byte == CH_VT) || (i_rx_byte == CH_FF);
    assign c_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign c_minus = (i_rx_byte == CH_MINUS);
    assign c_sign  = (i_rx_byte == CH_PLUS) || c_minus;
    assign left_acc  = accumulate(r_lmag, i_rx_byte[3:0]);
    assign right_acc = accumulate(r_rmag, i_rx_byte[3:0]);

    assign o_left_duty  = clamp(r_lmag, i_pwm_limit);
    assign o_right_duty = clamp(r_rmag, i_pwm_limit);

    always_comb begin
        n_phase = r_phase;
        n_lmag  = r_lmag;
        n_lneg  = r_lneg;
        n_rmag  = r_rmag;
        n_rneg  = r_rneg;
        o_ctl.push          = 1'b0;
        o_ctl.left_forward  = (r_lmag != '0) && !r_lneg;
        o_ctl.left_reverse  = (r_lmag != '0) && r_lneg;
        o_ctl.right_forward = (r_rmag != '0) && !r_rneg;
        o_ctl.right_reverse = (r_rmag != '0) && r_rneg;
        if (i_valid && (i_rx_byte != CH_CR)) begin
            if (i_rx_byte == CH_LF) begin
                o_ctl.push = (r_phase == PH_R_BLANK) || (r_phase == PH_R_SIGN) ||
                             (r_phase == PH_R_DIG) || (r_phase == PH_R_DONE);
                n_phase = PH_START;
                n_lmag  = '0;
                n_lneg  = 1'b0;
                n_rmag  = '0;
                n_rneg  = 1'b0;
            end else begin
                case (r_phase)
                    PH_START: begin
                        n_phase = (i_rx_byte == CH_P) ? PH_COLON : PH_REJECT;
                    end
                    PH_COLON: begin
                        n_phase = (i_rx_byte == CH_COLON) ? PH_L_BLANK : PH_REJECT;
                    end
                    PH_L_BLANK: begin
                        if (i_rx_byte == CH_COMMA) begin
                            n_phase = PH_R_BLANK;
                        end else if (c_blank) begin
                            n_phase = PH_L_BLANK;
                        end else if (c_sign) begin
                            n_lneg  = c_minus;
                            n_phase = PH_L_SIGN;
                        end else if (c_digit) begin
                            n_lmag  = left_acc;
                            n_phase = PH_L_DIG;
                        end else begin
                            n_phase = PH_L_DONE;
                        end
                    end
                    PH_L_SIGN, PH_L_DIG: begin
                        if (i_rx_byte == CH_COMMA) begin
                            n_phase = PH_R_BLANK;
                        end else if (c_digit) begin
                            n_lmag  = left_acc;
                            n_phase = PH_L_DIG;
                        end else begin
                            n_phase = PH_L_DONE;
                        end
                    end
                    PH_L_DONE: begin
                        if (i_rx_byte == CH_COMMA) begin
                            n_phase = PH_R_BLANK;
                        end
                    end
                    PH_R_BLANK: begin
                        if (c_blank) begin
                            n_phase = PH_R_BLANK;
                        end else if (c_sign) begin
                            n_rneg  = c_minus;
                            n_phase = PH_R_SIGN;
                        end else if (c_digit) begin
                            n_rmag  = right_acc;
                            n_phase = PH_R_DIG;
                        end else begin
                            n_phase = PH_R_DONE;
                        end
                    end
                    PH_R_SIGN, PH_R_DIG: begin
                        if (c_digit) begin
                            n_rmag  = right_acc;
                            n_phase = PH_R_DIG;
                        end else begin
                            n_phase = PH_R_DONE;
                        end
                    end
                    PH_R_DONE: begin
                        n_phase = PH_R_DONE;
                    end
                    default: begin
                        n_phase = PH_REJECT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_lmag  <= '0;
            r_lneg  <= 1'b0;
            r_rmag  <= '0;
            r_rneg  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_lmag  <= n_lmag;
            r_lneg  <= n_lneg;
            r_rmag  <= n_rmag;
            r_rneg  <= n_rneg;
        end
    end

endmodule

FILE: sv/serial_dual_motor_command_parser_unit.sv
// ----------------------------------------------------------------------------
// serial_dual_motor_command_parser_unit
// Reads "P:<left>,<right>" command lines from received characters and gives
// one drive result per valid line.
//
//   channel  dir  handshake     payload
//   i_rx     in   valid/ready   rx_byte
//   o_drv    out  valid/ready   left/right forward, reverse, duty
//   cfg      in   i_cfg_we      i_cfg_wdata = pwm_limit
//
// one character per cycle while the skid register is empty; a result is registered from its newline
// the parser state updates in the same cycle the character transfers
// results go to an output register backed by a one-entry skid register
// i_rx.ready drops only while the skid register holds a result
// synchronous reset: parser idle at line start, pwm_limit back to 255
// ----------------------------------------------------------------------------
module serial_dual_motor_command_parser_unit import sdmcp_pkg::*; #(
    parameter int DUTY_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    sdmcp_byte_if.sink             i_rx,
    sdmcp_drive_if.source          o_drv,
    input  logic                   i_cfg_we,
    input  logic [DUTY_BITS-1:0]   i_cfg_wdata
);

    localparam int RES_W = 4 + 2 * DUTY_BITS;

    logic [DUTY_BITS-1:0] r_pwm_limit;
    logic                 r_out_valid, r_skd_valid;
    logic [RES_W-1:0]     r_out_data, r_skd_data;
    logic [RES_W-1:0]     n_res;

    t_res_ctl             ctl;
    logic [DUTY_BITS-1:0] left_duty, right_duty;
    logic                 accept, pop;

    assign i_rx.ready = !r_skd_valid;
    assign accept     = i_rx.valid && i_rx.ready;
    assign pop        = r_out_valid && o_drv.ready;

    sdmcp_parse #(
        .DUTY_BITS (DUTY_BITS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_rx_byte    (i_rx.rx_byte),
        .i_pwm_limit  (r_pwm_limit),
        .o_ctl        (ctl),
        .o_left_duty  (left_duty),
        .o_right_duty (right_duty)
    );

    assign n_res = {ctl.left_forward, ctl.left_reverse, left_duty,
                    ctl.right_forward, ctl.right_reverse, right_duty};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_limit <= DUTY_BITS'(PWM_LIMIT_RESET);
        end else if (i_cfg_we) begin
            r_pwm_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (pop) begin
            if (r_skd_valid) begin
                r_out_data  <= r_skd_data;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= ctl.push;
                r_out_data  <= n_res;
            end
        end else if (ctl.push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
                r_out_data  <= n_res;
            end else begin
                r_skd_valid <= 1'b1;
                r_skd_data  <= n_res;
            end
        end
    end

    assign o_drv.valid         = r_out_valid;
    assign o_drv.left_forward  = r_out_data[RES_W-1];
    assign o_drv.left_reverse  = r_out_data[RES_W-2];
    assign o_drv.left_duty     = r_out_data[RES_W-3 -: DUTY_BITS];
    assign o_drv.right_forward = r_out_data[DUTY_BITS+1];
    assign o_drv.right_reverse = r_out_data[DUTY_BITS];
    assign o_drv.right_duty    = r_out_data[DUTY_BITS-1:0];

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_push_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.push && r_out_valid && !o_drv.ready) |=> r_skd_valid)
        else $error("result lost while output stalled");

    a_duty_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_drv.valid |-> (o_drv.left_duty <= r_pwm_limit &&
                         o_drv.right_duty <= r_pwm_limit))
        else $error("duty above pwm limit");

    a_dir_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_drv.valid |-> !(o_drv.left_forward && o_drv.left_reverse) &&
                        !(o_drv.right_forward && o_drv.right_reverse))
        else $error("forward and reverse both set");

    a_push_needs_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push |-> accept && i_rx.rx_byte == CH_LF)
        else $error("result produced without a newline transfer");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the dual motor command parser. It sends command lines
// byte by byte: directed corner lines first, then random lines, most of them
// well formed, the rest broken or noise. The run goes through four phases,
// each with its own pwm limit and its own idle and stall pattern. A
// scoreboard tracks the parser state, predicts each drive result and checks
// every result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
    import sdmcp_pkg::*;

    localparam int DUTY_BITS = 10;
    localparam int MAG_MAX = (1 << (DUTY_BITS + 1)) - 1;
    localparam int CHARS_PER_PHASE = 450;

    typedef struct packed {
        logic                 left_forward;
        logic                 left_reverse;
        logic [DUTY_BITS-1:0] left_duty;
        logic                 right_forward;
        logic                 right_reverse;
        logic [DUTY_BITS-1:0] right_duty;
    } t_drive;

    class drive_scoreboard;
        t_phase               phase;
        logic [DUTY_BITS-1:0] limit;
        logic [DUTY_BITS:0]   l_mag;
        logic [DUTY_BITS:0]   r_mag;
        logic                 l_neg;
        logic                 r_neg;
        t_drive               pending[$];
        int                   n_checked;
        int                   n_errors;

        function new();
            limit     = DUTY_BITS'(PWM_LIMIT_RESET);
            phase     = PH_START;
            l_mag     = '0;
            r_mag     = '0;
            l_neg     = 1'b0;
            r_neg     = 1'b0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void set_limit(logic [DUTY_BITS-1:0] v);
            limit = v;
        endfunction

        // offset within a number field: 0 blanks, 1 sign, 2 digits, 3 done
        function int field_step(int off, logic [7:0] c, inout logic [DUTY_BITS:0] mag,
                                inout logic neg);
            int v;
            if (off == 0) begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) return 0;
                if (c == CH_PLUS || c == CH_MINUS) begin
                    neg = (c == CH_MINUS);
                    return 1;
                end
            end
            if (off <= 2 && c >= CH_ZERO && c <= CH_NINE) begin
                v = int'(mag) * 10 + int'(c - CH_ZERO);
                mag = (v > MAG_MAX) ? MAG_MAX[DUTY_BITS:0] : v[DUTY_BITS:0];
                return 2;
            end
            return 3;
        endfunction

        function void motor(logic [DUTY_BITS:0] mag, logic neg, output logic fwd,
                            output logic rev, output logic [DUTY_BITS-1:0] duty);
            fwd  = (mag != 0) && !neg;
            rev  = (mag != 0) && neg;
            duty = (mag > limit) ? limit : mag[DUTY_BITS-1:0];
        endfunction

        function void note_char(logic [7:0] c);
            t_drive d;
            if (c == CH_CR) return;
            if (c == CH_LF) begin
                if (phase >= PH_R_BLANK && phase <= PH_R_DONE) begin
                    motor(l_mag, l_neg, d.left_forward, d.left_reverse, d.left_duty);
                    motor(r_mag, r_neg, d.right_forward, d.right_reverse, d.right_duty);
                    pending.push_back(d);
                end
                phase = PH_START;
                l_mag = '0;
                r_mag = '0;
                l_neg = 1'b0;
                r_neg = 1'b0;
                return;
            end
            case (phase)
                PH_START: phase = (c == CH_P) ? PH_COLON : PH_REJECT;
                PH_COLON: phase = (c == CH_COLON) ? PH_L_BLANK : PH_REJECT;
                PH_L_BLANK, PH_L_SIGN, PH_L_DIG, PH_L_DONE: begin
                    if (c == CH_COMMA) begin
                        phase = PH_R_BLANK;
                    end else begin
                        phase = t_phase'(int'(PH_L_BLANK)
                            + field_step(int'(phase) - int'(PH_L_BLANK), c, l_mag, l_neg));
                    end
                end
                PH_R_BLANK, PH_R_SIGN, PH_R_DIG, PH_R_DONE: begin
                    phase = t_phase'(int'(PH_R_BLANK)
                        + field_step(int'(phase) - int'(PH_R_BLANK), c, r_mag, r_neg));
                end
                default: phase = PH_REJECT;
            endcase
        endfunction

        function void check_drive(t_drive got);
            t_drive want;
            if (pending.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: drive result with none expected: L %b%b/%0d R %b%b/%0d",
                             $realtime, got.left_forward, got.left_reverse, got.left_duty,
                             got.right_forward, got.right_reverse, got.right_duty);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.left_forward !== want.left_forward || got.left_reverse !== want.left_reverse
                || got.left_duty !== want.left_duty
                || got.right_forward !== want.right_forward
                || got.right_reverse !== want.right_reverse
                || got.right_duty !== want.right_duty) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: exp L %b%b/%0d R %b%b/%0d, got L %b%b/%0d R %b%b/%0d",
                             $realtime, want.left_forward, want.left_reverse, want.left_duty,
                             want.right_forward, want.right_reverse, want.right_duty,
                             got.left_forward, got.left_reverse, got.left_duty,
                             got.right_forward, got.right_reverse, got.right_duty);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [DUTY_BITS-1:0] i_cfg_wdata;

    sdmcp_byte_if                         rx_if ();
    sdmcp_drive_if #(.DUTY_BITS(DUTY_BITS)) drv_if ();

    serial_dual_motor_command_parser_unit #(
        .DUTY_BITS(DUTY_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_if),
        .o_drv      (drv_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    drive_scoreboard      sb = new();
    int                   idle_pct;
    int                   stall_pct;
    int                   n_chars;
    logic [7:0]           line_chars[$];
    logic [DUTY_BITS-1:0] phase_limit[4];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // result side: check each transfer, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_if.ready <= 1'b0;
        end else begin
            if (drv_if.valid && drv_if.ready)
                sb.check_drive({drv_if.left_forward, drv_if.left_reverse, drv_if.left_duty,
                                drv_if.right_forward, drv_if.right_reverse, drv_if.right_duty});
            drv_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_char(input logic [7:0] c);
        if ($urandom_range(0, 99) < idle_pct) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= c;
        do @(posedge i_clk); while (!rx_if.ready);
        sb.note_char(c);
        if (c != CH_CR) n_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic drain_results();
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    task automatic write_limit(input logic [DUTY_BITS-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_limit(v);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic void push_number();
        int r;
        int n_dig;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
            line_chars.push_back(pick_blank());
        r = $urandom_range(0, 2);
        if (r == 1) line_chars.push_back(CH_PLUS);
        if (r == 2) line_chars.push_back(CH_MINUS);
        r = $urandom_range(0, 19);
        n_dig = (r == 0) ? 0 : (r < 17) ? $urandom_range(1, 3) : $urandom_range(4, 6);
        repeat (n_dig) line_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        r = $urandom_range(0, 9);
        if (r == 0) begin
            line_chars.push_back(pick_blank());
            line_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (r == 1) begin
            line_chars.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // mostly well formed lines with random content, some broken, some noise
    function automatic void build_line();
        int r;
        line_chars.delete();
        r = $urandom_range(0, 99);
        if (r < 75) begin
            line_chars.push_back(CH_P);
            line_chars.push_back(CH_COLON);
            push_number();
            line_chars.push_back(CH_COMMA);
            push_number();
            if ($urandom_range(0, 9) == 0) begin
                line_chars.push_back(CH_COMMA);
                push_number();
            end
        end else if (r < 90) begin
            case ($urandom_range(0, 3))
                0: begin
                    line_chars.push_back(CH_P);
                    line_chars.push_back(CH_COLON);
                    push_number();
                end
                1: begin
                    line_chars.push_back(8'($urandom_range(0, 255)));
                    line_chars.push_back(CH_COLON);
                    push_number();
                    line_chars.push_back(CH_COMMA);
                    push_number();
                end
                2: begin
                    line_chars.push_back(CH_P);
                    line_chars.push_back(8'($urandom_range(0, 255)));
                    push_number();
                    line_chars.push_back(CH_COMMA);
                    push_number();
                end
                default: ;
            endcase
        end else begin
            repeat ($urandom_range(1, 12)) line_chars.push_back(8'($urandom_range(0, 255)));
        end
        line_chars.push_back(CH_LF);
    endfunction

    initial begin
        bit paused;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        n_chars       = 0;
        phase_limit   = '{DUTY_BITS'(1023), DUTY_BITS'(0),
                          DUTY_BITS'($urandom_range(1, 1022)), DUTY_BITS'($urandom_range(1, 300))};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner lines at the reset limit
        send_text("P:99999,-0\n");
        send_text("P:\t-3 9,\f+\r\n");
        send_text("P;1,2\n");
        send_text("Q:1,2\n");
        send_text("P:5\n");
        send_text("\n");
        send_text("P:+7,12,4\377\n");
        send_char(8'h00);
        send_char(CH_LF);

        for (int p = 0; p < 4; p++) begin
            drain_results();
            repeat (4) @(posedge i_clk);
            write_limit(phase_limit[p]);
            idle_pct  = (p == 1) ? 73 : (p == 3) ? 28 : 0;
            stall_pct = (p == 2) ? 73 : (p == 3) ? 28 : 0;
            paused = 1'b0;
            for (int k = n_chars; n_chars - k < CHARS_PER_PHASE; ) begin
                build_line();
                foreach (line_chars[i]) begin
                    if ($urandom_range(0, 19) == 0) send_char(CH_CR);
                    send_char(line_chars[i]);
                end
                if (!paused && n_chars - k >= CHARS_PER_PHASE / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("sent %0d characters over directed lines and four idle/stall phases",
                 n_chars);
        $display("checked %0d drive results with pwm limits 255, %0d, %0d, %0d and %0d",
                 sb.n_checked, phase_limit[0], phase_limit[1], phase_limit[2],
                 phase_limit[3]);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (sb.n_errors > 10) $display("%0d mismatches in total", sb.n_errors);
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
